// File: rtl/query_term_field_statistics_macros.svh
// Assertion macros for the query term field statistics block.
`ifndef QUERY_TERM_FIELD_STATISTICS_MACROS_SVH
`define QUERY_TERM_FIELD_STATISTICS_MACROS_SVH
`define QTFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define QTFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/qtfs_pkg.sv
// Package with constants, types and helpers of the query term field statistics block.
`default_nettype none
package qtfs_pkg;
  localparam int QUERY_TERMS = 16;
  localparam int FIELDS      = 2;
  localparam int SLOTS       = QUERY_TERMS + 1;
  localparam int IDX_W       = (QUERY_TERMS > 1) ? $clog2(QUERY_TERMS) : 1;
  localparam int FILL_W      = $clog2(QUERY_TERMS + 1);
  localparam int WALK_W      = $clog2(QUERY_TERMS + 2);
  localparam int FLD_W       = (FIELDS > 1) ? $clog2(FIELDS) : 1;
  localparam int CSLOT_W     = $clog2(FIELDS * QUERY_TERMS);
  localparam int DEPTH       = FIELDS * SLOTS;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int ID_W        = 31;
  localparam int CNT_W       = 16;
  localparam int LEN_W       = 20;
  localparam int ENTRY_W     = 5;
  localparam int DIVIDEND_W  = 32;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_TERM = 2'd1;
  localparam logic [1:0] FUNC_EOD  = 2'd2;
  localparam logic [1:0] FUNC_READ = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic [31:0] doc_count;
    logic [31:0] total_count;
    logic [47:0] ratio_sum;
  } stats_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
  endfunction
endpackage
`default_nettype wire

// File: rtl/qtfs_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
`default_nettype none
module qtfs_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [qtfs_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [qtfs_pkg::LEN_W-1:0]        divisor_i,
  output logic                                   done_o,
  output logic [qtfs_pkg::DIVIDEND_W-1:0]        quotient_o
);
  localparam int STEP_W = $clog2(qtfs_pkg::DIVIDEND_W + 1);

  logic [qtfs_pkg::LEN_W:0]        rem_q, rem_sh;
  logic [qtfs_pkg::DIVIDEND_W-1:0] quo_q;
  logic [qtfs_pkg::LEN_W-1:0]      div_q;
  logic [STEP_W-1:0]               step_q;
  logic                            run_q, done_q;
  logic                            fits;

  assign rem_sh = {rem_q[qtfs_pkg::LEN_W-1:0], quo_q[qtfs_pkg::DIVIDEND_W-1]};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (run_q) begin
        rem_q <= fits ? rem_sh - {1'b0, div_q} : rem_sh;
        quo_q <= {quo_q[qtfs_pkg::DIVIDEND_W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == STEP_W'(qtfs_pkg::DIVIDEND_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

// File: rtl/qtfs_stats.sv
// Statistics memory with per-entry valid bits so that unwritten entries read as zero.
`default_nettype none
module qtfs_stats (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [qtfs_pkg::ADDR_W-1:0]   waddr_i,
  input  wire qtfs_pkg::stats_t              wdata_i,
  input  wire logic                          re_i,
  input  wire logic [qtfs_pkg::ADDR_W-1:0]   raddr_i,
  output qtfs_pkg::stats_t                   rdata_o
);
  qtfs_pkg::stats_t             mem_q [qtfs_pkg::DEPTH];
  qtfs_pkg::stats_t             rd_q;
  logic [qtfs_pkg::DEPTH-1:0]   vld_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;
endmodule
`default_nettype wire

// File: rtl/query_term_field_statistics.sv
// Top level of the query term field statistics block with its sequencer.
// Usage: a request is taken at a rising edge with start_i high and busy_o low.
// func_i selects load query term, term occurrence, end of document or read entry.
// Exactly one result follows each request: done_o is high for one cycle with
// status_o, entry_term_o, doc_count_o, total_count_o and ratio_sum_o valid.
// The receiver cannot stall; the result must be taken in that cycle.
// Load and term requests finish in S_EXEC, which registers the result strobe.
// Read requests with a valid field and index go on to S_RD for the statistics memory read.
// End of document walks every table slot of every field with nonzero length,
// one slot per step. A slot with a nonzero count waits in S_WAIT for the
// shared restoring divider; a zero slot advances in S_SLOT, and the totals
// slot waits in S_WAIT for its memory read but skips the divider.
// busy_o is high from acceptance until the result strobe, and a new request
// may be accepted in the strobe cycle.
// Reset clears the table fill, the per-document counts and lengths and all
// statistics; loaded term ids are undefined until written.
`default_nettype none
module query_term_field_statistics (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  func_i,
  input  wire logic        field_i,
  input  wire logic [30:0] term_id_i,
  input  wire logic [4:0]  entry_index_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [30:0]      entry_term_o,
  output logic [31:0]      doc_count_o,
  output logic [31:0]      total_count_o,
  output logic [47:0]      ratio_sum_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RD, S_SLOT, S_WAIT
  } state_e;

  localparam int QT = qtfs_pkg::QUERY_TERMS;

  state_e                              state_q;
  logic [1:0]                          func_q;
  logic                                field_q;
  logic [qtfs_pkg::ID_W-1:0]           id_q;
  logic [qtfs_pkg::ENTRY_W-1:0]        idx_q;
  logic [qtfs_pkg::FILL_W-1:0]         fill_q;
  logic [qtfs_pkg::ID_W-1:0]           ids_q [QT];
  logic [qtfs_pkg::CNT_W-1:0]          cnt_q [qtfs_pkg::FIELDS*QT];
  logic [qtfs_pkg::LEN_W-1:0]          len_q [qtfs_pkg::FIELDS];
  logic [qtfs_pkg::FLD_W-1:0]          f_q;
  logic [qtfs_pkg::WALK_W-1:0]         i_q;
  logic [qtfs_pkg::LEN_W-1:0]          cur_q;
  logic                                done_q;
  logic [1:0]                          status_q;
  logic [qtfs_pkg::ID_W-1:0]           term_q;
  qtfs_pkg::stats_t                    res_q;

  logic                                accept;
  logic [QT-1:0]                       hit;
  logic                                hit_any;
  logic [qtfs_pkg::IDX_W-1:0]          hit_idx;
  logic                                field_ok;
  logic                                rd_ok;
  logic [qtfs_pkg::LEN_W-1:0]          cur_len;
  logic [qtfs_pkg::CNT_W-1:0]          cur_cnt;
  logic                                is_total;
  logic [qtfs_pkg::ADDR_W-1:0]         walk_addr, rd_addr;
  logic                                mem_re, mem_we;
  logic [qtfs_pkg::ADDR_W-1:0]         mem_raddr;
  qtfs_pkg::stats_t                    mem_rdata, mem_wdata;
  logic                                div_start, div_done;
  logic [qtfs_pkg::DIVIDEND_W-1:0]     div_quo;
  logic [47:0]                         ratio_add;

  assign busy_o = state_q != S_IDLE;
  assign accept = start_i && !busy_o;

  always_comb begin
    hit_idx = '0;
    for (int k = QT - 1; k >= 0; k--) begin
      hit[k] = (qtfs_pkg::FILL_W'(k) < fill_q) && (ids_q[k] == id_q);
      if (hit[k]) begin
        hit_idx = qtfs_pkg::IDX_W'(k);
      end
    end
  end
  assign hit_any = |hit;

  assign field_ok = 32'(field_q) < qtfs_pkg::FIELDS;
  assign rd_ok = field_ok && ((32'(idx_q) < QT && 32'(idx_q) < 32'(fill_q)) ||
                              32'(idx_q) == QT);
  assign rd_addr = qtfs_pkg::ADDR_W'(32'(field_q) * qtfs_pkg::SLOTS + 32'(idx_q));

  assign is_total  = 32'(i_q) == QT;
  assign cur_len   = len_q[f_q];
  assign cur_cnt   = cnt_q[qtfs_pkg::CSLOT_W'(32'(f_q) * QT + 32'(i_q[qtfs_pkg::IDX_W-1:0]))];
  assign walk_addr = qtfs_pkg::ADDR_W'(32'(f_q) * qtfs_pkg::SLOTS + 32'(i_q));

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = walk_addr;
    div_start = 1'b0;
    if (state_q == S_EXEC && func_q == qtfs_pkg::FUNC_READ && rd_ok) begin
      mem_re    = 1'b1;
      mem_raddr = rd_addr;
    end else if (state_q == S_SLOT && cur_len != '0 && 32'(i_q) <= QT &&
                 (is_total || cur_cnt != '0)) begin
      mem_re    = 1'b1;
      div_start = !is_total;
    end
  end

  assign ratio_add = is_total ? 48'h1_0000 : 48'(div_quo);
  assign mem_we    = state_q == S_WAIT && (is_total || div_done);
  assign mem_wdata.doc_count   = qtfs_pkg::sat_add32(mem_rdata.doc_count, 32'd1);
  assign mem_wdata.total_count = qtfs_pkg::sat_add32(mem_rdata.total_count, 32'(cur_q));
  assign mem_wdata.ratio_sum   = qtfs_pkg::sat_add48(mem_rdata.ratio_sum, ratio_add);

  qtfs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({cur_cnt, 16'h0000}),
    .divisor_i  (cur_len),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  qtfs_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (walk_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      field_q <= field_i;
      id_q    <= term_id_i;
      idx_q   <= entry_index_i;
    end
    if (state_q == S_EXEC && func_q == qtfs_pkg::FUNC_LOAD && id_q != '0 && !hit_any &&
        32'(fill_q) < QT) begin
      ids_q[fill_q[qtfs_pkg::IDX_W-1:0]] <= id_q;
    end
    if (mem_re && state_q == S_SLOT) begin
      cur_q <= is_total ? cur_len : qtfs_pkg::LEN_W'(cur_cnt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      f_q      <= '0;
      i_q      <= '0;
      done_q   <= 1'b0;
      status_q <= qtfs_pkg::STATUS_OK;
      term_q   <= '0;
      res_q    <= '0;
      for (int k = 0; k < qtfs_pkg::FIELDS * QT; k++) begin
        cnt_q[k] <= '0;
      end
      for (int k = 0; k < qtfs_pkg::FIELDS; k++) begin
        len_q[k] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_EXEC;
            f_q     <= '0;
            i_q     <= '0;
          end
        end
        S_EXEC: begin
          status_q <= qtfs_pkg::STATUS_OK;
          term_q   <= '0;
          res_q    <= '0;
          case (func_q)
            qtfs_pkg::FUNC_LOAD: begin
              if (id_q == '0 || hit_any) begin
                status_q <= qtfs_pkg::STATUS_IGNORED;
              end else if (32'(fill_q) >= QT) begin
                status_q <= qtfs_pkg::STATUS_FULL;
              end else begin
                fill_q <= fill_q + 1'b1;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
            qtfs_pkg::FUNC_TERM: begin
              if (field_ok && id_q != '0) begin
                if (len_q[field_q] != '1) begin
                  len_q[field_q] <= len_q[field_q] + 1'b1;
                end
                if (hit_any && cnt_q[qtfs_pkg::CSLOT_W'(32'(field_q) * QT + 32'(hit_idx))]
                    != '1) begin
                  cnt_q[qtfs_pkg::CSLOT_W'(32'(field_q) * QT + 32'(hit_idx))] <=
                    cnt_q[qtfs_pkg::CSLOT_W'(32'(field_q) * QT + 32'(hit_idx))] + 1'b1;
                end
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
            qtfs_pkg::FUNC_EOD: begin
              state_q <= S_SLOT;
            end
            qtfs_pkg::FUNC_READ: begin
              if (rd_ok) begin
                state_q <= S_RD;
              end else begin
                done_q  <= 1'b1;
                state_q <= S_IDLE;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_RD: begin
          term_q  <= (32'(idx_q) == QT) ? '0 : ids_q[idx_q[qtfs_pkg::IDX_W-1:0]];
          res_q   <= mem_rdata;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_SLOT: begin
          if (cur_len == '0 || 32'(i_q) > QT) begin
            if (32'(f_q) == qtfs_pkg::FIELDS - 1) begin
              for (int k = 0; k < qtfs_pkg::FIELDS * QT; k++) begin
                cnt_q[k] <= '0;
              end
              for (int k = 0; k < qtfs_pkg::FIELDS; k++) begin
                len_q[k] <= '0;
              end
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              f_q <= f_q + 1'b1;
              i_q <= '0;
            end
          end else if (mem_re) begin
            state_q <= S_WAIT;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_WAIT: begin
          if (mem_we) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SLOT;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_term_o  = term_q;
  assign doc_count_o   = res_q.doc_count;
  assign total_count_o = res_q.total_count;
  assign ratio_sum_o   = res_q.ratio_sum;

`include "query_term_field_statistics_macros.svh"
  `QTFS_ASSERT_NEXT(a_accept_busy, accept, busy_o)
  `QTFS_ASSERT_NEXT(a_single_strobe, done_o, !done_o)
  `QTFS_ASSERT_NOW(a_fill_bound, 1'b1, 32'(fill_q) <= QT)
  `QTFS_ASSERT_NOW(a_status_zero, done_o && |status_o, entry_term_o == '0 && doc_count_o == '0)
endmodule
`default_nettype wire

// File: dv/query_term_field_statistics_tb.sv
// Testbench for the query term field statistics block, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module query_term_field_statistics_tb;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_REQUESTS = 1700;

  typedef struct {
    logic [1:0]  status;
    logic [30:0] entry_term;
    logic [31:0] doc_count;
    logic [31:0] total_count;
    logic [47:0] ratio_sum;
  } stats_result_t;

  class term_stats_scoreboard;
    logic [30:0] ids[qtfs_pkg::QUERY_TERMS];
    int unsigned fill;
    logic [15:0] doc_hits[qtfs_pkg::FIELDS * qtfs_pkg::QUERY_TERMS];
    logic [19:0] doc_len[qtfs_pkg::FIELDS];
    logic [31:0] df[qtfs_pkg::DEPTH];
    logic [31:0] tf[qtfs_pkg::DEPTH];
    logic [47:0] rsum[qtfs_pkg::DEPTH];
    stats_result_t expected_q[$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
      foreach (doc_hits[i]) doc_hits[i] = '0;
      foreach (doc_len[i]) doc_len[i] = '0;
      foreach (df[i]) begin
        df[i] = '0;
        tf[i] = '0;
        rsum[i] = '0;
      end
    endfunction

    function int lookup(logic [30:0] id);
      for (int i = 0; i < fill; i++) if (ids[i] == id) return i;
      return -1;
    endfunction

    function logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? '1 : s[31:0];
    endfunction

    function logic [47:0] add_sat48(logic [47:0] a, logic [47:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[48] ? '1 : s[47:0];
    endfunction

    function void accumulate(int slot, logic [31:0] cnt, logic [31:0] len);
      logic [63:0] q;
      q = ({32'd0, cnt} << 16) / {32'd0, len};
      df[slot] = add_sat32(df[slot], 32'd1);
      tf[slot] = add_sat32(tf[slot], cnt);
      rsum[slot] = add_sat48(rsum[slot], q[47:0]);
    endfunction

    function void note_request(logic [1:0] func, logic field, logic [30:0] id,
                               logic [4:0] idx);
      stats_result_t r;
      int k;
      int slot;
      r = '{default: '0};
      case (func)
        qtfs_pkg::FUNC_LOAD: begin
          if (id == 0 || lookup(id) >= 0) r.status = qtfs_pkg::STATUS_IGNORED;
          else if (fill >= qtfs_pkg::QUERY_TERMS) r.status = qtfs_pkg::STATUS_FULL;
          else begin
            ids[fill] = id;
            fill++;
          end
        end
        qtfs_pkg::FUNC_TERM: begin
          if (id != 0) begin
            if (doc_len[field] != '1) doc_len[field]++;
            k = lookup(id);
            if (k >= 0 && doc_hits[field * qtfs_pkg::QUERY_TERMS + k] != '1)
              doc_hits[field * qtfs_pkg::QUERY_TERMS + k]++;
          end
        end
        qtfs_pkg::FUNC_EOD: begin
          for (int f = 0; f < qtfs_pkg::FIELDS; f++) begin
            if (doc_len[f] != 0) begin
              for (int i = 0; i < qtfs_pkg::QUERY_TERMS; i++)
                if (doc_hits[f * qtfs_pkg::QUERY_TERMS + i] != 0)
                  accumulate(f * qtfs_pkg::SLOTS + i,
                             doc_hits[f * qtfs_pkg::QUERY_TERMS + i], doc_len[f]);
              accumulate(f * qtfs_pkg::SLOTS + qtfs_pkg::QUERY_TERMS, doc_len[f],
                         doc_len[f]);
            end
            doc_len[f] = '0;
          end
          foreach (doc_hits[i]) doc_hits[i] = '0;
        end
        default: begin
          slot = field * qtfs_pkg::SLOTS + idx;
          if (idx < qtfs_pkg::QUERY_TERMS && idx < fill) r.entry_term = ids[idx];
          if ((idx < qtfs_pkg::QUERY_TERMS && idx < fill) || idx == qtfs_pkg::QUERY_TERMS)
          begin
            r.doc_count = df[slot];
            r.total_count = tf[slot];
            r.ratio_sum = rsum[slot];
          end
        end
      endcase
      expected_q = {expected_q, r};
    endfunction

    function void check_result(stats_result_t got);
      stats_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, got.status);
        errors++;
      end
      if (got.entry_term !== e.entry_term) begin
        $error("entry_term: expected %0h, actual %0h", e.entry_term, got.entry_term);
        errors++;
      end
      if (got.doc_count !== e.doc_count) begin
        $error("doc_count: expected %0d, actual %0d", e.doc_count, got.doc_count);
        errors++;
      end
      if (got.total_count !== e.total_count) begin
        $error("total_count: expected %0d, actual %0d", e.total_count, got.total_count);
        errors++;
      end
      if (got.ratio_sum !== e.ratio_sum) begin
        $error("ratio_sum: expected %0h, actual %0h", e.ratio_sum, got.ratio_sum);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  func_i = qtfs_pkg::FUNC_LOAD;
  logic        field_i = 1'b0;
  logic [30:0] term_id_i = '0;
  logic [4:0]  entry_index_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [30:0] entry_term_o;
  logic [31:0] doc_count_o;
  logic [31:0] total_count_o;
  logic [47:0] ratio_sum_o;

  term_stats_scoreboard stats_sb = new();
  int idle_cycles = 0;

  query_term_field_statistics dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .field_i, .term_id_i,
    .entry_index_i, .done_o, .status_o, .entry_term_o, .doc_count_o,
    .total_count_o, .ratio_sum_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      stats_sb.check_result('{status_o, entry_term_o, doc_count_o, total_count_o,
                              ratio_sum_o});
    if (done_o || (start_i && !busy_o) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] func, logic field, logic [30:0] id,
                              logic [4:0] idx, int gap);
    repeat (gap) @(negedge clk_i) start_i <= 1'b0;
    @(negedge clk_i);
    start_i <= 1'b1;
    func_i <= func;
    field_i <= field;
    term_id_i <= id;
    entry_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    stats_sb.note_request(func, field, id, idx);
  endtask

  task automatic drain();
    @(negedge clk_i) start_i <= 1'b0;
    while (stats_sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [30:0] pick_term();
    int p;
    p = $urandom_range(99);
    if (p < 10) return '0;
    if (p < 15) return 31'($urandom());
    if (p < 20) return '1;
    return 31'($urandom_range(1, 40));
  endfunction

  initial begin
    int p;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_LOAD, 1'b0, '0, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_LOAD, 1'b0, '1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_LOAD, 1'b0, 31'd1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_LOAD, 1'b0, 31'd1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b0, '1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b0, 31'd1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b0, 31'd1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b0, 31'd0, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b1, 31'd5, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_TERM, 1'b1, 31'd1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_EOD, 1'b0, '0, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd1, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b1, '0, 5'd1, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd16, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b1, '0, 5'd16, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd17, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b1, '0, 5'd31, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd5, 0);
    send_request(qtfs_pkg::FUNC_EOD, 1'b1, '1, 5'd0, 0);
    send_request(qtfs_pkg::FUNC_READ, 1'b0, '0, 5'd16, 0);
    drain();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 300 == 299) drain();
      p = $urandom_range(99);
      if (p < 10)
        send_request(qtfs_pkg::FUNC_LOAD, 1'($urandom()), pick_term(), 5'($urandom()),
                     pick_gap());
      else if (p < 68)
        send_request(qtfs_pkg::FUNC_TERM, 1'($urandom()), pick_term(), 5'($urandom()),
                     pick_gap());
      else if (p < 76)
        send_request(qtfs_pkg::FUNC_EOD, 1'($urandom()), 31'($urandom()), 5'($urandom()),
                     pick_gap());
      else
        send_request(qtfs_pkg::FUNC_READ, 1'($urandom()), 31'($urandom()),
                     ($urandom_range(3) == 0) ? 5'($urandom()) : 5'($urandom_range(16)),
                     pick_gap());
    end
    drain();
    repeat (20) @(posedge clk_i);
    if (stats_sb.errors == 0 && stats_sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
